// ===== rtl/core/callsign_route_table_top_macros.svh =====
// Assertion macros used by the route table controller.
`ifndef CALLSIGN_ROUTE_TABLE_TOP_MACROS_SVH
`define CALLSIGN_ROUTE_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CRT_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("route table assertion failed");
`define CRT_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("route table assertion failed");
`else
`define CRT_ASSERT_IMP(label, ante, cons)
`define CRT_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/crt_pkg.sv =====
`timescale 1ns / 1ps
package crt_pkg;
   localparam int ROUTE_DEPTH = 32;
   localparam int BCAST_DEPTH = 16;
   localparam int CALL_W = 56;
   localparam int ADDR_W = 64;
   localparam int PORT_W = 16;
   localparam int REQ_W  = 3;
   localparam int RIDX_W = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
   localparam int RCNT_W = $clog2(ROUTE_DEPTH + 1);
   localparam int BIDX_W = (BCAST_DEPTH > 1) ? $clog2(BCAST_DEPTH) : 1;
   localparam int BCNT_W = $clog2(BCAST_DEPTH + 1);

   localparam logic [REQ_W-1:0] REQ_ADD_ROUTE = 3'd0;
   localparam logic [REQ_W-1:0] REQ_ADD_BCAST = 3'd1;
   localparam logic [REQ_W-1:0] REQ_LOOKUP    = 3'd2;
   localparam logic [REQ_W-1:0] REQ_BTEST     = 3'd3;
   localparam logic [REQ_W-1:0] REQ_LIST      = 3'd4;
   localparam logic [REQ_W-1:0] REQ_FAMILY    = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_CHK, ST_LIST_OUT, ST_DEF_RD, ST_DEF_CHK, ST_BRD, ST_BCHK, ST_EMIT
   } state_type;

   typedef struct packed {
      logic [CALL_W-1:0] call;
      logic              family;
      logic [ADDR_W-1:0] addr_hi;
      logic [ADDR_W-1:0] addr_lo;
      logic [PORT_W-1:0] port;
      logic              bcast;
   } route_entry_type;

   typedef struct packed {
      logic              we;
      logic [RIDX_W-1:0] waddr;
      route_entry_type   wdata;
      logic              re;
      logic [RIDX_W-1:0] raddr;
   } rmem_ctl_type;

   typedef struct packed {
      logic              found;
      logic              used_default;
      logic              family;
      logic [ADDR_W-1:0] addr_hi;
      logic [ADDR_W-1:0] addr_lo;
      logic [PORT_W-1:0] port;
      logic              status;
      logic              last;
   } result_type;

   function automatic logic [CALL_W-1:0] normalize_call(input logic [CALL_W-1:0] raw);
      logic [CALL_W-1:0] c;
      c = raw;
      return {c[CALL_W-1:8] & 48'hFEFE_FEFE_FEFE, (c[7:0] & 8'h1E) | 8'h60};
   endfunction

   function automatic result_type route_result(input route_entry_type e, input logic use_def);
      result_type r;
      r = '0;
      r.found = 1'b1;
      r.used_default = use_def;
      r.family = e.family;
      r.addr_hi = e.addr_hi;
      r.addr_lo = e.addr_lo;
      r.port = e.port;
      return r;
   endfunction
endpackage

// ===== rtl/core/crt_rmem.sv =====
`timescale 1ns / 1ps
module crt_rmem (
   input  logic                    clock,
   input  crt_pkg::rmem_ctl_type   ctl,
   output crt_pkg::route_entry_type rdata
);
   import crt_pkg::*;

   route_entry_type mem [ROUTE_DEPTH];
   route_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) begin
         rdata_ff <= mem[ctl.raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/crt_ctrl.sv =====
`timescale 1ns / 1ps
`include "callsign_route_table_top_macros.svh"
module crt_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [crt_pkg::REQ_W-1:0]     req_type,
   input  logic [crt_pkg::CALL_W-1:0]    req_callsign,
   input  logic                          req_addr_family,
   input  logic [crt_pkg::ADDR_W-1:0]    req_addr_hi,
   input  logic [crt_pkg::ADDR_W-1:0]    req_addr_lo,
   input  logic [crt_pkg::PORT_W-1:0]    req_port,
   input  logic                          req_mark_default,
   input  logic                          req_mark_bcast,
   output crt_pkg::rmem_ctl_type         rmem_ctl,
   input  crt_pkg::route_entry_type      rmem_rdata,
   output logic                          res_valid,
   input  logic                          res_ready,
   output crt_pkg::result_type           res
);
   import crt_pkg::*;

   state_type          state_ff, state_in;
   logic [REQ_W-1:0]   rtype_ff, rtype_in;
   logic [CALL_W-1:0]  call_ff, call_in;
   logic               fam_ff, fam_in;
   logic [RCNT_W-1:0]  idx_ff, idx_in;
   logic [BCNT_W-1:0]  bidx_ff, bidx_in;
   logic [RCNT_W-1:0]  route_count_ff, route_count_in;
   logic               default_valid_ff, default_valid_in;
   logic [RIDX_W-1:0]  default_slot_ff, default_slot_in;
   logic [BCNT_W-1:0]  bcast_count_ff, bcast_count_in;
   logic               have_ff, have_in;
   result_type         res_ff, res_in;
   logic [CALL_W-1:0]  bmem [BCAST_DEPTH];
   logic [CALL_W-1:0]  bdata_ff;
   logic               bwe, bre;
   logic [CALL_W-1:0]  cmp_b;
   logic               hit_call;

   // One comparator serves both the route scan and the broadcast set scan.
   assign cmp_b    = (state_ff == ST_BCHK) ? bdata_ff : rmem_rdata.call;
   assign hit_call = (cmp_b == call_ff);

   always_ff @(posedge clock) begin
      if (bwe) begin
         bmem[bcast_count_ff[BIDX_W-1:0]] <= normalize_call(req_callsign);
      end
      if (bre) begin
         bdata_ff <= bmem[bidx_ff[BIDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         route_count_ff   <= '0;
         default_valid_ff <= 1'b0;
         default_slot_ff  <= '0;
         bcast_count_ff   <= '0;
         have_ff          <= 1'b0;
      end else begin
         state_ff         <= state_in;
         route_count_ff   <= route_count_in;
         default_valid_ff <= default_valid_in;
         default_slot_ff  <= default_slot_in;
         bcast_count_ff   <= bcast_count_in;
         have_ff          <= have_in;
      end
      rtype_ff <= rtype_in;
      call_ff  <= call_in;
      fam_ff   <= fam_in;
      idx_ff   <= idx_in;
      bidx_ff  <= bidx_in;
      res_ff   <= res_in;
   end

   always_comb begin
      state_in         = state_ff;
      rtype_in         = rtype_ff;
      call_in          = call_ff;
      fam_in           = fam_ff;
      idx_in           = idx_ff;
      bidx_in          = bidx_ff;
      route_count_in   = route_count_ff;
      default_valid_in = default_valid_ff;
      default_slot_in  = default_slot_ff;
      bcast_count_in   = bcast_count_ff;
      have_in          = have_ff;
      res_in           = res_ff;
      rmem_ctl         = '0;
      bwe              = 1'b0;
      bre              = 1'b0;
      req_ready        = 1'b0;
      res_valid        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rtype_in = req_type;
               call_in  = normalize_call(req_callsign);
               fam_in   = req_addr_family;
               idx_in   = '0;
               bidx_in  = '0;
               have_in  = 1'b0;
               res_in   = '0;
               state_in = ST_EMIT;
               case (req_type)
                  REQ_ADD_ROUTE: begin
                     if (route_count_ff >= RCNT_W'(ROUTE_DEPTH)) begin
                        res_in.status = 1'b1;
                     end else begin
                        rmem_ctl.we            = 1'b1;
                        rmem_ctl.waddr         = route_count_ff[RIDX_W-1:0];
                        rmem_ctl.wdata.call    = normalize_call(req_callsign);
                        rmem_ctl.wdata.family  = req_addr_family;
                        rmem_ctl.wdata.addr_hi = req_addr_family ? req_addr_hi : '0;
                        rmem_ctl.wdata.addr_lo = req_addr_family ? req_addr_lo
                                                 : {32'd0, req_addr_lo[31:0]};
                        rmem_ctl.wdata.port    = req_port;
                        rmem_ctl.wdata.bcast   = req_mark_bcast;
                        if (req_mark_default) begin
                           default_valid_in = 1'b1;
                           default_slot_in  = route_count_ff[RIDX_W-1:0];
                        end
                        route_count_in = route_count_ff + RCNT_W'(1);
                     end
                  end
                  REQ_ADD_BCAST: begin
                     if (bcast_count_ff >= BCNT_W'(BCAST_DEPTH)) begin
                        res_in.status = 1'b1;
                     end else begin
                        bwe            = 1'b1;
                        bcast_count_in = bcast_count_ff + BCNT_W'(1);
                     end
                  end
                  REQ_LOOKUP, REQ_LIST, REQ_FAMILY: begin
                     state_in = ST_RD;
                  end
                  REQ_BTEST: begin
                     state_in = ST_BRD;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_RD: begin
            if (idx_ff < route_count_ff) begin
               rmem_ctl.re    = 1'b1;
               rmem_ctl.raddr = idx_ff[RIDX_W-1:0];
               state_in       = ST_CHK;
            end else if (rtype_ff == REQ_LOOKUP && default_valid_ff) begin
               state_in = ST_DEF_RD;
            end else begin
               // The result register already holds the answer or zero.
               state_in = ST_EMIT;
            end
         end
         ST_CHK: begin
            idx_in   = idx_ff + RCNT_W'(1);
            state_in = ST_RD;
            case (rtype_ff)
               REQ_LOOKUP: begin
                  if (hit_call) begin
                     res_in   = route_result(rmem_rdata, 1'b0);
                     state_in = ST_EMIT;
                  end
               end
               REQ_FAMILY: begin
                  if (rmem_rdata.family == fam_ff) begin
                     res_in.found = 1'b1;
                     state_in     = ST_EMIT;
                  end
               end
               REQ_LIST: begin
                  // A held item goes out only once a later one proves it is not the last.
                  if (rmem_rdata.bcast) begin
                     if (have_ff) begin
                        state_in = ST_LIST_OUT;
                     end else begin
                        res_in  = route_result(rmem_rdata, 1'b0);
                        have_in = 1'b1;
                     end
                  end
               end
               default: begin
                  state_in = ST_EMIT;
               end
            endcase
         end
         ST_LIST_OUT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               res_in   = route_result(rmem_rdata, 1'b0);
               state_in = ST_RD;
            end
         end
         ST_DEF_RD: begin
            rmem_ctl.re    = 1'b1;
            rmem_ctl.raddr = default_slot_ff;
            state_in       = ST_DEF_CHK;
         end
         ST_DEF_CHK: begin
            res_in   = route_result(rmem_rdata, 1'b1);
            state_in = ST_EMIT;
         end
         ST_BRD: begin
            if (bidx_ff < bcast_count_ff) begin
               bre      = 1'b1;
               state_in = ST_BCHK;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_BCHK: begin
            if (hit_call) begin
               res_in.found = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               bidx_in  = bidx_ff + BCNT_W'(1);
               state_in = ST_BRD;
            end
         end
         ST_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res      = res_ff;
      res.last = (state_ff == ST_EMIT);
   end

   `CRT_ASSERT_IMP(a_count_bound, 1'b1, route_count_ff <= RCNT_W'(ROUTE_DEPTH))
   `CRT_ASSERT_IMP(a_default_slot, default_valid_ff, RCNT_W'(default_slot_ff) < route_count_ff)
   `CRT_ASSERT_IMP(a_busy_no_req, res_valid, !req_ready)
   `CRT_ASSERT_IMP(a_list_hold, state_ff == ST_LIST_OUT, have_ff && rtype_ff == REQ_LIST)
   `CRT_ASSERT_NXT(a_count_inc, rmem_ctl.we, route_count_ff == $past(route_count_ff) + RCNT_W'(1))
endmodule

// ===== rtl/core/callsign_route_table_top.sv =====
`timescale 1ns / 1ps
// Callsign route table: an ordered table of up to 32 routes keyed by normalised callsign,
// a default route and a set of up to 16 broadcast callsigns. One request is handled at a
// time. Adds write the table directly and answer from the result register; a lookup,
// family query or broadcast route listing reads the stored routes one after another
// through the single table read port (a lookup with no match then reads the default
// route, and a listing waits on the output for each broadcast-marked route after the
// first), and a broadcast test reads the broadcast callsigns in turn. Lookups and
// broadcast tests check callsigns with one shared comparator. A listing gives one item per
// broadcast-marked route, the last with rsp_last, or one empty item when there is none.
module callsign_route_table_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [crt_pkg::REQ_W-1:0]     req_type,
   input  logic [crt_pkg::CALL_W-1:0]    req_callsign,
   input  logic                          req_addr_family,
   input  logic [crt_pkg::ADDR_W-1:0]    req_addr_hi,
   input  logic [crt_pkg::ADDR_W-1:0]    req_addr_lo,
   input  logic [crt_pkg::PORT_W-1:0]    req_port,
   input  logic                          req_mark_default,
   input  logic                          req_mark_bcast,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic                          rsp_used_default,
   output logic                          rsp_out_family,
   output logic [crt_pkg::ADDR_W-1:0]    rsp_out_addr_hi,
   output logic [crt_pkg::ADDR_W-1:0]    rsp_out_addr_lo,
   output logic [crt_pkg::PORT_W-1:0]    rsp_out_port,
   output logic                          rsp_status,
   output logic                          rsp_last
);
   import crt_pkg::*;

   rmem_ctl_type    rmem_ctl;
   route_entry_type rmem_rdata;
   logic            res_valid, res_ready;
   result_type      res;
   logic            rsp_valid_ff, rsp_valid_in;
   result_type      rsp_ff, rsp_in;

   crt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_callsign     (req_callsign),
      .req_addr_family  (req_addr_family),
      .req_addr_hi      (req_addr_hi),
      .req_addr_lo      (req_addr_lo),
      .req_port         (req_port),
      .req_mark_default (req_mark_default),
      .req_mark_bcast   (req_mark_bcast),
      .rmem_ctl         (rmem_ctl),
      .rmem_rdata       (rmem_rdata),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res              (res)
   );

   crt_rmem u_rmem (
      .clock (clock),
      .ctl   (rmem_ctl),
      .rdata (rmem_rdata)
   );

   // The output register takes a new item whenever it is empty or being emptied.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_ff.found;
   assign rsp_used_default = rsp_ff.used_default;
   assign rsp_out_family   = rsp_ff.family;
   assign rsp_out_addr_hi  = rsp_ff.addr_hi;
   assign rsp_out_addr_lo  = rsp_ff.addr_lo;
   assign rsp_out_port     = rsp_ff.port;
   assign rsp_status       = rsp_ff.status;
   assign rsp_last         = rsp_ff.last;
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import crt_pkg::*;

   typedef struct {
      logic [REQ_W-1:0]  kind;
      logic [CALL_W-1:0] call;
      logic              fam;
      logic [ADDR_W-1:0] hi;
      logic [ADDR_W-1:0] lo;
      logic [PORT_W-1:0] port;
      logic              mdef;
      logic              mbc;
      bit                typed;   // expected result written into the row
      logic              tstatus;
   } route_req_type;

   localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
   localparam logic [CALL_W-1:0] CALL_ONES = {CALL_W{1'b1}};
   localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};
   // Bits that normalisation throws away.
   localparam logic [CALL_W-1:0] CALL_DONT_CARE = 56'h01_0101_0101_01E1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [REQ_W-1:0]  req_type = '0;
   logic [CALL_W-1:0] req_callsign = '0;
   logic              req_addr_family = 1'b0;
   logic [ADDR_W-1:0] req_addr_hi = '0;
   logic [ADDR_W-1:0] req_addr_lo = '0;
   logic [PORT_W-1:0] req_port = '0;
   logic              req_mark_default = 1'b0;
   logic              req_mark_bcast = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_found, rsp_used_default, rsp_out_family, rsp_status, rsp_last;
   logic [ADDR_W-1:0] rsp_out_addr_hi, rsp_out_addr_lo;
   logic [PORT_W-1:0] rsp_out_port;

   callsign_route_table_top dut (.*);

   always #1 clock = ~clock;

   // Shadow copy of the route table and broadcast set.
   logic [CALL_W-1:0] tbl_call [ROUTE_DEPTH];
   logic              tbl_fam  [ROUTE_DEPTH];
   logic [ADDR_W-1:0] tbl_hi   [ROUTE_DEPTH];
   logic [ADDR_W-1:0] tbl_lo   [ROUTE_DEPTH];
   logic [PORT_W-1:0] tbl_port [ROUTE_DEPTH];
   logic              tbl_bc   [ROUTE_DEPTH];
   int                tbl_count = 0;
   bit                dflt_valid = 0;
   int                dflt_slot = 0;
   logic [CALL_W-1:0] bset_call [BCAST_DEPTH];
   int                bset_count = 0;

   result_type expected_rsp_q[$];
   int errors = 0;
   bit stall_kick = 0;

   function automatic logic [CALL_W-1:0] canon_call(input logic [CALL_W-1:0] raw);
      return {raw[CALL_W-1:8] & 48'hFEFE_FEFE_FEFE, (raw[7:0] & 8'h1E) | 8'h60};
   endfunction

   function automatic result_type plain_rsp(input logic found, input logic status);
      result_type r;
      r = '0;
      r.found = found;
      r.status = status;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic result_type entry_rsp(input int i, input logic dflt);
      result_type r;
      r = '0;
      r.found = 1'b1;
      r.used_default = dflt;
      r.family = tbl_fam[i];
      r.addr_hi = tbl_hi[i];
      r.addr_lo = tbl_lo[i];
      r.port = tbl_port[i];
      return r;
   endfunction

   // Updates the shadow state and, when keep is set, queues every result the request causes.
   task automatic predict_routes(input route_req_type it, input bit keep);
      logic [CALL_W-1:0] c;
      result_type r;
      result_type outs[$];
      bit hit;
      c = canon_call(it.call);
      case (it.kind)
         REQ_ADD_ROUTE: begin
            if (tbl_count >= ROUTE_DEPTH) begin
               outs.push_back(plain_rsp(1'b0, 1'b1));
            end else begin
               tbl_call[tbl_count] = c;
               tbl_fam[tbl_count] = it.fam;
               tbl_hi[tbl_count] = it.fam ? it.hi : '0;
               tbl_lo[tbl_count] = it.fam ? it.lo : {32'd0, it.lo[31:0]};
               tbl_port[tbl_count] = it.port;
               tbl_bc[tbl_count] = it.mbc;
               if (it.mdef) begin
                  dflt_valid = 1;
                  dflt_slot = tbl_count;
               end
               tbl_count++;
               outs.push_back(plain_rsp(1'b0, 1'b0));
            end
         end
         REQ_ADD_BCAST: begin
            if (bset_count >= BCAST_DEPTH) begin
               outs.push_back(plain_rsp(1'b0, 1'b1));
            end else begin
               bset_call[bset_count] = c;
               bset_count++;
               outs.push_back(plain_rsp(1'b0, 1'b0));
            end
         end
         REQ_LOOKUP: begin
            hit = 0;
            for (int i = 0; i < tbl_count && !hit; i++) begin
               if (tbl_call[i] == c) begin
                  r = entry_rsp(i, 1'b0);
                  hit = 1;
               end
            end
            if (!hit && dflt_valid) r = entry_rsp(dflt_slot, 1'b1);
            else if (!hit) r = plain_rsp(1'b0, 1'b0);
            r.last = 1'b1;
            outs.push_back(r);
         end
         REQ_BTEST: begin
            hit = 0;
            for (int i = 0; i < bset_count; i++) if (bset_call[i] == c) hit = 1;
            outs.push_back(plain_rsp(hit, 1'b0));
         end
         REQ_LIST: begin
            for (int i = 0; i < tbl_count; i++) if (tbl_bc[i]) outs.push_back(entry_rsp(i, 1'b0));
            if (outs.size() == 0) outs.push_back(plain_rsp(1'b0, 1'b0));
            else outs[outs.size()-1].last = 1'b1;
         end
         REQ_FAMILY: begin
            hit = 0;
            for (int i = 0; i < tbl_count; i++) if (tbl_fam[i] == it.fam) hit = 1;
            outs.push_back(plain_rsp(hit, 1'b0));
         end
         default: outs.push_back(plain_rsp(1'b0, 1'b0));
      endcase
      if (keep) foreach (outs[k]) expected_rsp_q.push_back(outs[k]);
   endtask

   task automatic send_req(input route_req_type it);
      req_valid <= 1'b1;
      req_type <= it.kind;
      req_callsign <= it.call;
      req_addr_family <= it.fam;
      req_addr_hi <= it.hi;
      req_addr_lo <= it.lo;
      req_port <= it.port;
      req_mark_default <= it.mdef;
      req_mark_bcast <= it.mbc;
      do @(posedge clock); while (!req_ready);
      predict_routes(it, !it.typed);
      if (it.typed) expected_rsp_q.push_back(plain_rsp(1'b0, it.tstatus));
   endtask

   function automatic route_req_type mk_req(input logic [REQ_W-1:0] kind,
                                            input logic [CALL_W-1:0] call,
                                            input logic fam, input logic [ADDR_W-1:0] hi,
                                            input logic [ADDR_W-1:0] lo,
                                            input logic [PORT_W-1:0] port,
                                            input logic mdef, input logic mbc,
                                            input bit typed, input logic tstatus);
      route_req_type it;
      it.kind = kind; it.call = call; it.fam = fam; it.hi = hi; it.lo = lo;
      it.port = port; it.mdef = mdef; it.mbc = mbc; it.typed = typed; it.tstatus = tstatus;
      return it;
   endfunction

   task automatic check_rsp();
      result_type got, want;
      got.found = rsp_found;
      got.used_default = rsp_used_default;
      got.family = rsp_out_family;
      got.addr_hi = rsp_out_addr_hi;
      got.addr_lo = rsp_out_addr_lo;
      got.port = rsp_out_port;
      got.status = rsp_status;
      got.last = rsp_last;
      if (expected_rsp_q.size() == 0) begin
         $display("%0t: unexpected result item %p", $realtime, got);
         errors++;
      end else begin
         want = expected_rsp_q.pop_front();
         if (got.found !== want.found) begin
            $display("%0t: found exp %0h got %0h", $realtime, want.found, got.found);
            errors++;
         end
         if (got.used_default !== want.used_default) begin
            $display("%0t: used_default exp %0h got %0h", $realtime, want.used_default,
                     got.used_default);
            errors++;
         end
         if (got.family !== want.family) begin
            $display("%0t: family exp %0h got %0h", $realtime, want.family, got.family);
            errors++;
         end
         if (got.addr_hi !== want.addr_hi) begin
            $display("%0t: addr_hi exp %0h got %0h", $realtime, want.addr_hi, got.addr_hi);
            errors++;
         end
         if (got.addr_lo !== want.addr_lo) begin
            $display("%0t: addr_lo exp %0h got %0h", $realtime, want.addr_lo, got.addr_lo);
            errors++;
         end
         if (got.port !== want.port) begin
            $display("%0t: port exp %0h got %0h", $realtime, want.port, got.port);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status exp %0h got %0h", $realtime, want.status, got.status);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last exp %0h got %0h", $realtime, want.last, got.last);
            errors++;
         end
      end
   endtask

   // Receiver: steps through three stall patterns, with one long hold-off.
   int rx_cycle = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_rsp();
      rx_cycle++;
      if (stall_kick && !hold_done) begin
         hold_left = 400;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case ((rx_cycle / 256) % 3)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(3) != 0);
            default: rsp_ready <= ($urandom_range(5) == 0);
         endcase
      end
   end

   initial begin
      #4ms;
      $display("testbench: FAIL");
      $finish;
   end

   logic [CALL_W-1:0] call_pool [12];
   route_req_type directed[$];

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic route_req_type rand_req();
      route_req_type it;
      int pick;
      pick = $urandom_range(99);
      if (pick < 25) it.kind = REQ_ADD_ROUTE;
      else if (pick < 35) it.kind = REQ_ADD_BCAST;
      else if (pick < 65) it.kind = REQ_LOOKUP;
      else if (pick < 77) it.kind = REQ_BTEST;
      else if (pick < 85) it.kind = REQ_LIST;
      else if (pick < 96) it.kind = REQ_FAMILY;
      else it.kind = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
      if ($urandom_range(9) < 7)
         it.call = call_pool[$urandom_range(11)] ^ (CALL_W'(rand64()) & CALL_DONT_CARE);
      else
         it.call = CALL_W'(rand64());
      it.fam = 1'($urandom_range(1));
      it.hi = rand64();
      it.lo = rand64();
      it.port = PORT_W'($urandom);
      it.mdef = ($urandom_range(4) == 0);
      it.mbc = 1'($urandom_range(1));
      it.typed = 0;
      it.tstatus = 0;
      return it;
   endfunction

   initial begin
      int burst;
      int gap;
      route_req_type it;
      foreach (call_pool[k]) call_pool[k] = CALL_W'(rand64());
      call_pool[0] = CALL_ONES;
      call_pool[1] = '0;

      // Empty table first, then extreme adds, then queries on them.
      directed.push_back(mk_req(REQ_LOOKUP, '0, 0, 0, 0, 0, 0, 0, 1, 0));
      directed.push_back(mk_req(REQ_LIST, CALL_ONES, 1, 0, 0, 0, 1, 1, 1, 0));
      directed.push_back(mk_req(REQ_FAMILY, '0, 0, 0, 0, 0, 0, 0, 1, 0));
      directed.push_back(mk_req(REQ_FAMILY, '0, 1, 0, 0, 0, 0, 0, 1, 0));
      directed.push_back(mk_req(REQ_BTEST, CALL_ONES, 0, 0, 0, 0, 0, 0, 1, 0));
      directed.push_back(mk_req(REQ_SPARE_LO, '0, 0, 0, 0, 0, 0, 0, 1, 0));
      directed.push_back(mk_req(REQ_SPARE_HI, CALL_ONES, 1, ADDR_ONES, ADDR_ONES,
                                16'hFFFF, 1, 1, 1, 0));
      directed.push_back(mk_req(REQ_ADD_ROUTE, CALL_ONES, 0, ADDR_ONES, ADDR_ONES,
                                16'hFFFF, 0, 1, 1, 0));
      directed.push_back(mk_req(REQ_ADD_ROUTE, '0, 1, ADDR_ONES, ADDR_ONES, 0, 1, 0, 1, 0));
      directed.push_back(mk_req(REQ_LOOKUP, CALL_ONES, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_req(REQ_LOOKUP, CALL_ONES ^ CALL_DONT_CARE, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_req(REQ_LOOKUP, CALL_DONT_CARE, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_req(REQ_LOOKUP, 56'h12_3456_789A_BCDE, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_req(REQ_LIST, '0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_req(REQ_FAMILY, '0, 1, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_req(REQ_FAMILY, '0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_req(REQ_ADD_BCAST, CALL_ONES, 0, 0, 0, 0, 0, 0, 1, 0));
      directed.push_back(mk_req(REQ_BTEST, CALL_ONES ^ CALL_DONT_CARE, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_req(REQ_BTEST, '0, 0, 0, 0, 0, 0, 0, 0, 0));
      // A second route on the same callsign must not shadow the first.
      directed.push_back(mk_req(REQ_ADD_ROUTE, CALL_ONES, 1, 64'h0123_4567_89AB_CDEF,
                                64'hFEDC_BA98_7654_3210, 16'h8000, 1, 1, 1, 0));
      directed.push_back(mk_req(REQ_LOOKUP, CALL_ONES, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_req(REQ_LOOKUP, 56'hAA_AAAA_AAAA_AAAA, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_req(REQ_LIST, '0, 0, 0, 0, 0, 0, 0, 0, 0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[k]) send_req(directed[k]);

      burst = $urandom_range(20, 1);
      for (int n = 0; n < 360; n++) begin
         if (n == 120) stall_kick <= 1'b1;
         if (n == 250) begin
            req_valid <= 1'b0;
            while (expected_rsp_q.size() != 0) @(posedge clock);
            repeat (80) @(posedge clock);
         end
         it = rand_req();
         send_req(it);
         burst--;
         if (burst <= 0) begin
            burst = $urandom_range(20, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
